/* rtl/preamble_ccsds_packet_deframer_macros.svh */
// ----------------------------------------------------------------------------
// Packet deframer assertion macros
// Clocked concurrent checks with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef PREAMBLE_CCSDS_PACKET_DEFRAMER_MACROS_SVH
`define PREAMBLE_CCSDS_PACKET_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop on every rising edge of clk while reset is released.
`define PCD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cond never holds.
`define PCD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`PCD_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define PCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/pcd_pkg.sv */
// ----------------------------------------------------------------------------
// pcd_pkg
// Types and constants shared by the packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pcd_pkg;

	localparam logic [31:0] PREAMBLE  = 32'hAAAA_AAAA;
	localparam int          HDR_SIZE  = 6;
	localparam int          HDR_POS_W = $clog2(HDR_SIZE);

	// configuration register indexes
	localparam logic [1:0] REG_APID_BASE  = 2'd0;
	localparam logic [1:0] REG_FIRST_ID   = 2'd1;
	localparam logic [1:0] REG_LAST_ID    = 2'd2;
	localparam logic [1:0] REG_MAX_LENGTH = 2'd3;

	localparam logic [15:0] RST_APID_BASE  = 16'd0;
	localparam logic [15:0] RST_FIRST_ID   = 16'd0;
	localparam logic [15:0] RST_LAST_ID    = 16'd31;
	localparam logic [15:0] RST_MAX_LENGTH = 16'd512;

	typedef struct packed {
		logic [15:0] apid_base;
		logic [15:0] first_id;
		logic [15:0] last_id;
		logic [15:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [15:0] packet_id;
		logic [1:0]  packet_type;
		logic [13:0] packet_tic;
		logic [15:0] packet_length;
		logic        header_reject;
		logic [15:0] good_packets;
		logic [15:0] failed_packets;
	} result_t;

endpackage

`default_nettype wire

/* rtl/pcd_in_reg.sv */
// ----------------------------------------------------------------------------
// pcd_in_reg
// Input register: holds one received byte until the framer consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// stall only while a held byte cannot move on
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

/* rtl/pcd_core.sv */
// ----------------------------------------------------------------------------
// pcd_core
// Framing state: preamble hunt, header capture and decode, payload count.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_core
	import pcd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_s1,
	input  wire cfg_t       cfg,
	output result_t         res
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [HDR_POS_W-1:0] HDR_LAST = HDR_POS_W'(HDR_SIZE - 1);

	logic [31:0]              sync_q, sync_d;
	logic [1:0]               phase_q, phase_d;
	logic [2:0]               hcount_q, hcount_d;
	logic [HDR_SIZE-1:0][7:0] hdr_q, hdr_d;
	logic [15:0]              pcount_q, pcount_d;
	logic [15:0]              pexp_q, pexp_d;
	logic [15:0]              good_q, good_d;
	logic [15:0]              fail_q, fail_d;

	logic [HDR_POS_W-1:0] pos;
	logic [31:0]          sync_shifted;
	logic [15:0]          id, len;
	logic [15:0]          word1;
	logic                 hdr_bad;
	logic [16:0]          pcount_inc;
	logic                 show;

	always_comb begin
		pos = (hcount_q >= 3'(HDR_SIZE)) ? HDR_LAST : HDR_POS_W'(hcount_q);
		sync_shifted = {sync_q[23:0], byte_s1};

		hdr_d = hdr_q;
		if (phase_q == PH_HEADER) begin
			hdr_d[pos] = byte_s1;
		end
		id      = {hdr_d[1], hdr_d[0]} - cfg.apid_base;
		word1   = {hdr_d[3], hdr_d[2]};
		len     = {hdr_d[5], hdr_d[4]};
		hdr_bad = (len > cfg.max_length) || (len == 16'd0) ||
			(id < cfg.first_id) || (id > cfg.last_id);
		pcount_inc = {1'b0, pcount_q} + 17'd1;

		sync_d   = sync_q;
		phase_d  = phase_q;
		hcount_d = hcount_q;
		pcount_d = pcount_q;
		pexp_d   = pexp_q;
		good_d   = good_q;
		fail_d   = fail_q;
		show     = 1'b0;

		res.payload_valid = 1'b0;
		res.payload_byte  = 8'd0;
		res.payload_last  = 1'b0;
		res.header_reject = 1'b0;

		unique case (phase_q)
			PH_HUNT: begin
				sync_d = sync_shifted;
				if (sync_shifted == PREAMBLE) begin
					phase_d  = PH_HEADER;
					sync_d   = 32'd0;
					hcount_d = 3'd0;
				end
			end
			PH_HEADER: begin
				hcount_d = 3'({1'b0, pos} + 4'd1);
				if (pos == HDR_LAST) begin
					show = 1'b1;
					if (hdr_bad) begin
						res.header_reject = 1'b1;
						fail_d   = fail_q + 16'd1;
						phase_d  = PH_HUNT;
						sync_d   = 32'd0;
						hcount_d = 3'd0;
						pcount_d = 16'd0;
					end else begin
						pexp_d   = len;
						pcount_d = 16'd0;
						phase_d  = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				show = 1'b1;
				res.payload_valid = 1'b1;
				res.payload_byte  = byte_s1;
				if (pcount_inc >= {1'b0, pexp_q}) begin
					res.payload_last = 1'b1;
					good_d   = good_q + 16'd1;
					phase_d  = PH_HUNT;
					hcount_d = 3'd0;
					pcount_d = 16'd0;
					pexp_d   = 16'd0;
				end else begin
					pcount_d = pcount_inc[15:0];
				end
			end
			default: begin
				// unused phase: drop the byte and resume hunting
				phase_d = PH_HUNT;
				sync_d  = 32'd0;
			end
		endcase

		res.packet_id      = show ? id : 16'd0;
		res.packet_type    = show ? word1[1:0] : 2'd0;
		res.packet_tic     = show ? word1[15:2] : 14'd0;
		res.packet_length  = show ? len : 16'd0;
		res.good_packets   = good_d;
		res.failed_packets = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q   <= 32'd0;
			phase_q  <= PH_HUNT;
			hcount_q <= 3'd0;
			hdr_q    <= '0;
			pcount_q <= 16'd0;
			pexp_q   <= 16'd0;
			good_q   <= 16'd0;
			fail_q   <= 16'd0;
		end else if (step) begin
			sync_q   <= sync_d;
			phase_q  <= phase_d;
			hcount_q <= hcount_d;
			hdr_q    <= hdr_d;
			pcount_q <= pcount_d;
			pexp_q   <= pexp_d;
			good_q   <= good_d;
			fail_q   <= fail_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/pcd_out_reg.sv */
// ----------------------------------------------------------------------------
// pcd_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_out_reg
	import pcd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    valid_s1,
	input  wire result_t res,
	output logic         advance,
	input  wire logic    out_stall,
	output logic         out_valid,
	output result_t      res_s2
);

	logic open_s2;

	assign open_s2 = !out_valid || !out_stall;
	assign advance = valid_s1 && open_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (open_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

/* rtl/preamble_ccsds_packet_deframer.sv */
// ----------------------------------------------------------------------------
// preamble_ccsds_packet_deframer
// Byte-stream packet deframer: hunts the 0xAAAAAAAA preamble, decodes a
// six-byte little-endian header and passes the declared payload bytes out.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    rx_byte
//   output    out        out_valid / out_stall  payload_*, packet_*, counts
//   config    in         cfg_we                 cfg_index, cfg_data
//
// Every received byte gives exactly one result. The byte lands in the input
// register, the framer decodes it in one pass and the result register
// captures it. One byte per cycle is sustained while out_stall stays low; the
// framing state update between the two registers sets that figure.
// Reset (arst_n low) clears framing state, counters and registers to defaults.
// A stall on the output holds the result and, once the input register is
// full, backs up onto in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "preamble_ccsds_packet_deframer_macros.svh"

module preamble_ccsds_packet_deframer
	import pcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// received byte stream
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	// result stream
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             payload_valid,
	output logic [7:0]       payload_byte,
	output logic             payload_last,
	output logic [15:0]      packet_id,
	output logic [1:0]       packet_type,
	output logic [13:0]      packet_tic,
	output logic [15:0]      packet_length,
	output logic             header_reject,
	output logic [15:0]      good_packets,
	output logic [15:0]      failed_packets
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	result_t    res;
	result_t    res_s2;

	// Configuration registers. The user is to write them only while the pipe is
	// empty; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.apid_base  <= RST_APID_BASE;
			cfg_q.first_id   <= RST_FIRST_ID;
			cfg_q.last_id    <= RST_LAST_ID;
			cfg_q.max_length <= RST_MAX_LENGTH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_APID_BASE:  cfg_q.apid_base  <= cfg_data;
				REG_FIRST_ID:   cfg_q.first_id   <= cfg_data;
				REG_LAST_ID:    cfg_q.last_id    <= cfg_data;
				REG_MAX_LENGTH: cfg_q.max_length <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// Hold the accepted byte until the framer can take it.
	pcd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Advance framing state exactly when a byte moves into the result register.
	pcd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_s1 (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// Register the result; a free or draining slot lets the next byte in.
	pcd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.advance   (advance),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_s2    (res_s2)
	);

	assign payload_valid  = res_s2.payload_valid;
	assign payload_byte   = res_s2.payload_byte;
	assign payload_last   = res_s2.payload_last;
	assign packet_id      = res_s2.packet_id;
	assign packet_type    = res_s2.packet_type;
	assign packet_tic     = res_s2.packet_tic;
	assign packet_length  = res_s2.packet_length;
	assign header_reject  = res_s2.header_reject;
	assign good_packets   = res_s2.good_packets;
	assign failed_packets = res_s2.failed_packets;

	// The last-byte mark only ever rides on a payload byte.
	`PCD_ASSERT(a_last_is_payload, clk, arst_n,
		out_valid && payload_last |-> payload_valid, "payload_last without payload_valid")
	// A rejected header and a payload byte never share one result.
	`PCD_ASSERT_NEVER(a_reject_not_payload, clk, arst_n,
		out_valid && header_reject && payload_valid, "reject on a payload byte")
	// A rejected header bumps the failure count by one.
	`PCD_ASSERT(a_fail_count, clk, arst_n,
		advance && res.header_reject |=>
		failed_packets == 16'($past(failed_packets) + 16'd1), "failure count slip")
	// A completed packet bumps the good count by one.
	`PCD_ASSERT(a_good_count, clk, arst_n,
		advance && res.payload_last |=>
		good_packets == 16'($past(good_packets) + 16'd1), "good count slip")

endmodule

`default_nettype wire

/* dv/deframer_result_checker.sv */
// ----------------------------------------------------------------------------
// deframer_result_checker
// Watches the byte and result channels of the packet deframer, tracks the
// framing state on every byte transfer and compares each result transfer
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module deframer_result_checker
	import pcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        payload_valid,
	input  logic [7:0]  payload_byte,
	input  logic        payload_last,
	input  logic [15:0] packet_id,
	input  logic [1:0]  packet_type,
	input  logic [13:0] packet_tic,
	input  logic [15:0] packet_length,
	input  logic        header_reject,
	input  logic [15:0] good_packets,
	input  logic [15:0] failed_packets,
	output int          pending,
	output int          fail_count,
	output int          packets_done,
	output int          headers_rejected
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PRINTED = 100;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_e;

	cfg_t        regs;
	phase_e      phase;
	logic [31:0] sync_shift;
	logic [2:0]  hdr_count;
	logic [47:0] hdr_bytes;
	logic [15:0] pay_count;
	logic [15:0] pay_expected;
	logic [15:0] good_count;
	logic [15:0] reject_count;

	result_t expected_results[$];
	result_t seen;
	int      errors = 0;
	int      depth = 0;
	int      delivered = 0;
	int      rejected = 0;
	int      result_index = 0;

	assign seen = {payload_valid, payload_byte, payload_last, packet_id, packet_type,
		packet_tic, packet_length, header_reject, good_packets, failed_packets};
	assign pending          = depth;
	assign fail_count       = errors;
	assign packets_done     = delivered;
	assign headers_rejected = rejected;

	task automatic report_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s got 0x%0h want 0x%0h",
				result_index, name, got, want));
	endtask

	// advance the framing state by one byte and return the result it gives
	function automatic result_t deframe_byte(input logic [7:0] b);
		result_t     r;
		logic        show;
		logic [2:0]  pos;
		logic [15:0] id;
		logic [15:0] len;
		r    = '0;
		show = 1'b0;
		case (phase)
			PH_HUNT: begin
				sync_shift = {sync_shift[23:0], b};
				if (sync_shift == PREAMBLE) begin
					phase      = PH_HEADER;
					sync_shift = '0;
					hdr_count  = '0;
				end
			end
			PH_HEADER: begin
				pos = (int'(hdr_count) >= HDR_SIZE) ? 3'(HDR_SIZE - 1) : hdr_count;
				hdr_bytes[8*pos +: 8] = b;
				hdr_count = pos + 3'd1;
				if (int'(pos) + 1 >= HDR_SIZE) begin
					len  = hdr_bytes[47:32];
					id   = hdr_bytes[15:0] - regs.apid_base;
					show = 1'b1;
					if (len > regs.max_length || len == 16'd0 ||
						id < regs.first_id || id > regs.last_id) begin
						r.header_reject = 1'b1;
						reject_count++;
						rejected++;
						phase      = PH_HUNT;
						sync_shift = '0;
						hdr_count  = '0;
						pay_count  = '0;
					end else begin
						pay_expected = len;
						pay_count    = '0;
						phase        = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				r.payload_valid = 1'b1;
				r.payload_byte  = b;
				show            = 1'b1;
				if (32'(pay_count) + 1 >= 32'(pay_expected)) begin
					r.payload_last = 1'b1;
					good_count++;
					delivered++;
					phase        = PH_HUNT;
					hdr_count    = '0;
					pay_count    = '0;
					pay_expected = '0;
				end else begin
					pay_count++;
				end
			end
			default: begin
				// drop the byte and resume hunting
				phase      = PH_HUNT;
				sync_shift = '0;
			end
		endcase
		if (show) begin
			r.packet_id     = hdr_bytes[15:0] - regs.apid_base;
			r.packet_type   = hdr_bytes[17:16];
			r.packet_tic    = hdr_bytes[31:18];
			r.packet_length = hdr_bytes[47:32];
		end
		r.good_packets   = good_count;
		r.failed_packets = reject_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs         = '{RST_APID_BASE, RST_FIRST_ID, RST_LAST_ID, RST_MAX_LENGTH};
			phase        = PH_HUNT;
			sync_shift   = '0;
			hdr_count    = '0;
			hdr_bytes    = '0;
			pay_count    = '0;
			pay_expected = '0;
			good_count   = '0;
			reject_count = '0;
			expected_results.delete();
			depth = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_error($sformatf("result %0d arrived with nothing expected",
						result_index));
				end else begin
					want = expected_results.pop_front();
					check_field("payload_valid", 16'(seen.payload_valid), 16'(want.payload_valid));
					check_field("payload_byte", 16'(seen.payload_byte), 16'(want.payload_byte));
					check_field("payload_last", 16'(seen.payload_last), 16'(want.payload_last));
					check_field("packet_id", seen.packet_id, want.packet_id);
					check_field("packet_type", 16'(seen.packet_type), 16'(want.packet_type));
					check_field("packet_tic", 16'(seen.packet_tic), 16'(want.packet_tic));
					check_field("packet_length", seen.packet_length, want.packet_length);
					check_field("header_reject", 16'(seen.header_reject), 16'(want.header_reject));
					check_field("good_packets", seen.good_packets, want.good_packets);
					check_field("failed_packets", seen.failed_packets, want.failed_packets);
				end
				result_index++;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_APID_BASE:  regs.apid_base  = cfg_data;
					REG_FIRST_ID:   regs.first_id   = cfg_data;
					REG_LAST_ID:    regs.last_id    = cfg_data;
					REG_MAX_LENGTH: regs.max_length = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_results.push_back(deframe_byte(rx_byte));
			depth = expected_results.size();
		end
	end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Top of the packet deframer bench: drives preamble-framed packets, broken
// preambles and line noise through a sequence of register settings, with
// random gaps and back-pressure, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
	import pcd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PHASES       = 8;
	localparam int          PHASE_BYTES  = 180;
	localparam int          QUIET_PHASE  = 5;
	localparam int          IDLE_PCT     = 26;
	localparam int          SETTLE       = 4;
	localparam int unsigned LIMIT_CYCLES = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_APID_BASE;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        payload_last;
	logic [15:0] packet_id;
	logic [1:0]  packet_type;
	logic [13:0] packet_tic;
	logic [15:0] packet_length;
	logic        header_reject;
	logic [15:0] good_packets;
	logic [15:0] failed_packets;

	int          pending;
	int          fail_count;
	int          packets_done;
	int          headers_rejected;
	int          bytes_sent = 0;
	int unsigned cycle_count = 0;
	logic        quiet = 1'b0;
	cfg_t        cur;

	always #4 clk = ~clk;

	preamble_ccsds_packet_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.payload_last  (payload_last),
		.packet_id     (packet_id),
		.packet_type   (packet_type),
		.packet_tic    (packet_tic),
		.packet_length (packet_length),
		.header_reject (header_reject),
		.good_packets  (good_packets),
		.failed_packets(failed_packets)
	);

	deframer_result_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_valid   (payload_valid),
		.payload_byte    (payload_byte),
		.payload_last    (payload_last),
		.packet_id       (packet_id),
		.packet_type     (packet_type),
		.packet_tic      (packet_tic),
		.packet_length   (packet_length),
		.header_reject   (header_reject),
		.good_packets    (good_packets),
		.failed_packets  (failed_packets),
		.pending         (pending),
		.fail_count      (fail_count),
		.packets_done    (packets_done),
		.headers_rejected(headers_rejected)
	);

	// Back-pressure on the result side: random stall, none in the quiet phase.
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	// Watchdog: end the run if the bench hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL preamble_ccsds_packet_deframer");
			$finish;
		end
	end

	// Send one byte: outside the quiet phase insert random gap cycles first,
	// then hold the byte with valid high until the edge that completes the
	// transfer. in_stall is read right after the edge, before the block
	// updates it, so it is the value the block saw at that edge.
	task automatic send_byte(input logic [7:0] b);
		if (!quiet) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_preamble();
		for (int i = 3; i >= 0; i--)
			send_byte(PREAMBLE[8*i +: 8]);
	endtask

	// Header is three little-endian words: pid, psc, pdl.
	task automatic send_header(input logic [15:0] pid, input logic [15:0] psc,
		input logic [15:0] pdl);
		send_byte(pid[7:0]);
		send_byte(pid[15:8]);
		send_byte(psc[7:0]);
		send_byte(psc[15:8]);
		send_byte(pdl[7:0]);
		send_byte(pdl[15:8]);
	endtask

	// Drop valid and wait for the block to drain: every expected result out,
	// then a settle wait to cover the two-stage pipeline. The pending
	// count is read before the checker updates it at the same edge, so it can
	// only read high late, never low early.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_setting(input cfg_t s);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_APID_BASE;
		cfg_data  <= s.apid_base;
		@(posedge clk);
		cfg_index <= REG_FIRST_ID;
		cfg_data  <= s.first_id;
		@(posedge clk);
		cfg_index <= REG_LAST_ID;
		cfg_data  <= s.last_id;
		@(posedge clk);
		cfg_index <= REG_MAX_LENGTH;
		cfg_data  <= s.max_length;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur = s;
	endtask

	// One framed packet with random content, led in now and then by noise or
	// a broken preamble. Lengths stay short so most traffic is framing work.
	task automatic send_packet();
		logic [15:0] id;
		logic [15:0] pid;
		logic [15:0] psc;
		logic [15:0] len;
		logic        accepted;
		int          pick;
		int          cap;
		pick = $urandom_range(99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		end else if (pick < 16) begin
			// cut the preamble short with a byte that can never extend it
			repeat ($urandom_range(1, 3)) send_byte(PREAMBLE[7:0]);
			send_byte(8'($urandom_range(0, 169)));
		end
		send_preamble();
		if ($urandom_range(99) < 80 && cur.first_id <= cur.last_id)
			id = cur.first_id + 16'($urandom_range(0, 32'(cur.last_id - cur.first_id)));
		else
			id = 16'($urandom);
		cap = (cur.max_length == 16'd0 || cur.max_length > 16'd12) ? 12 : int'(cur.max_length);
		pick = $urandom_range(99);
		if (pick < 70)
			len = 16'($urandom_range(1, cap));
		else if (pick < 80)
			len = 16'd0;
		else if (pick < 90)
			len = cur.max_length + 16'd1;
		else if (cur.max_length != 16'd0 && cur.max_length <= 16'd40)
			len = cur.max_length;
		else
			len = 16'($urandom_range(1, cap));
		pid = id + cur.apid_base;
		psc = 16'($urandom);
		send_header(pid, psc, len);
		accepted = len != 16'd0 && len <= cur.max_length &&
			id >= cur.first_id && id <= cur.last_id;
		if (accepted)
			repeat (len) send_byte(8'($urandom));
		else if ($urandom_range(99) < 30)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
	endtask

	initial begin
		cfg_t settings[PHASES];
		int   stop_at;

		cur = '{RST_APID_BASE, RST_FIRST_ID, RST_LAST_ID, RST_MAX_LENGTH};
		settings[0] = cur;
		settings[1] = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF};
		settings[2] = '{16'h0000, 16'h0000, 16'h0000, 16'h0001};
		settings[3] = '{16'($urandom), 16'h0010, 16'h0020, 16'h0000};
		settings[4] = '{16'h1234, 16'h8000, 16'h7FFF, 16'h0010};
		settings[5] = '{16'($urandom), 16'($urandom), 16'h0000, 16'($urandom_range(8, 40))};
		settings[5].last_id = settings[5].first_id + 16'($urandom_range(0, 64));
		settings[6] = '{16'h0001, 16'hFFF0, 16'hFFFF, 16'h0003};
		settings[7] = '{16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom_range(1, 64))};

		// hold reset, then release it once
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: smallest packet at the lowest id with every type and tic
		// bit set, then a zero-length header at the highest id, rejected.
		send_preamble();
		send_header(16'h0000, 16'hFFFF, 16'd1);
		send_byte(8'hFF);
		send_preamble();
		send_header(16'h001F, 16'h0000, 16'd0);

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0)
				write_setting(settings[p]);
			quiet   = (p == QUIET_PHASE);
			stop_at = bytes_sent + PHASE_BYTES;
			while (bytes_sent < stop_at)
				send_packet();
		end

		drain();
		$display("Sent %0d bytes across %0d register settings, reset defaults included.",
			bytes_sent, PHASES);
		$display("Framer delivered %0d packets and rejected %0d headers.",
			packets_done, headers_rejected);
		if (fail_count == 0)
			$display("PASS preamble_ccsds_packet_deframer");
		else
			$display("FAIL preamble_ccsds_packet_deframer");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/pcd_pkg.sv
rtl/pcd_in_reg.sv
rtl/pcd_core.sv
rtl/pcd_out_reg.sv
rtl/preamble_ccsds_packet_deframer.sv
dv/deframer_result_checker.sv
dv/tb.sv
